// File: design/cmap_pkg.sv
// ----------------------------------------------------------------------------
// cmap_pkg
// Shared constants, register and mode codes and the small constant tables of
// the constellation symbol mapper.
// ----------------------------------------------------------------------------
package cmap_pkg;

    // default sizes
    localparam int MAX_SYMBOL_BITS = 12;
    localparam int SAMPLE_WIDTH    = 16;

    // field and port widths
    localparam int SYM_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int MODE_W     = 5;
    localparam int RATIO_W    = 16;
    localparam int GAIN_W     = 18;
    localparam int ANG_W      = 7;
    localparam int TRIG_W     = 15;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_ORDER   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_FOUR  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_GAIN   = 3'd5;

    // mode codes
    localparam logic [MODE_W-1:0] MODE_BPSK    = 5'd0;
    localparam logic [MODE_W-1:0] MODE_QPSK    = 5'd1;
    localparam logic [MODE_W-1:0] MODE_PSK8    = 5'd2;
    localparam logic [MODE_W-1:0] MODE_PSK16   = 5'd3;
    localparam logic [MODE_W-1:0] MODE_QAM16   = 5'd4;
    localparam logic [MODE_W-1:0] MODE_QAM4096 = 5'd12;
    localparam logic [MODE_W-1:0] MODE_APSK16  = 5'd13;
    localparam logic [MODE_W-1:0] MODE_APSK32  = 5'd14;
    localparam logic [MODE_W-1:0] MODE_STAR16  = 5'd15;
    localparam logic [MODE_W-1:0] MODE_STAR32  = 5'd16;

    // reset values
    localparam logic [MODE_W-1:0]  MODE_RST        = MODE_QPSK;
    localparam logic [RATIO_W-1:0] RATIO_TWO_RST   = 16'd8192;
    localparam logic [RATIO_W-1:0] RATIO_THREE_RST = 16'd12288;
    localparam logic [RATIO_W-1:0] RATIO_FOUR_RST  = 16'd16384;
    localparam logic [GAIN_W-1:0]  NORM_GAIN_RST   = 18'd46341;

    // inner ring radius, 1.0 in Q4.12
    localparam logic [RATIO_W-1:0] RADIUS_ONE = 16'd4096;
    // unit trig value, 1.0 in Q1.14
    localparam logic [TRIG_W-1:0]  TRIG_ONE   = 15'd16384;

    typedef struct packed {
        logic              neg;
        logic [TRIG_W-1:0] mag;
    } trig_t;

    // quarter-wave sine, round(sin(k*pi/48)*16384)
    function automatic logic [TRIG_W-1:0] sin_mag(input logic [4:0] k);
        logic [TRIG_W-1:0] s;
        case (k)
            5'd0:    s = 15'd0;
            5'd1:    s = 15'd1072;
            5'd2:    s = 15'd2139;
            5'd3:    s = 15'd3196;
            5'd4:    s = 15'd4240;
            5'd5:    s = 15'd5266;
            5'd6:    s = 15'd6270;
            5'd7:    s = 15'd7246;
            5'd8:    s = 15'd8192;
            5'd9:    s = 15'd9102;
            5'd10:   s = 15'd9974;
            5'd11:   s = 15'd10803;
            5'd12:   s = 15'd11585;
            5'd13:   s = 15'd12318;
            5'd14:   s = 15'd12998;
            5'd15:   s = 15'd13623;
            5'd16:   s = 15'd14189;
            5'd17:   s = 15'd14694;
            5'd18:   s = 15'd15137;
            5'd19:   s = 15'd15515;
            5'd20:   s = 15'd15826;
            5'd21:   s = 15'd16069;
            5'd22:   s = 15'd16244;
            5'd23:   s = 15'd16349;
            5'd24:   s = 15'd16384;
            default: s = 15'd0;
        endcase
        return s;
    endfunction

    // signed sine at a pi/48 step, angle taken modulo a full turn
    function automatic trig_t trig_at(input logic [ANG_W-1:0] a);
        logic [ANG_W-1:0] w;
        trig_t t;
        w = (a >= 7'd96) ? a - 7'd96 : a;
        if (w <= 7'd24)
        begin
            t.neg = 1'b0;
            t.mag = sin_mag(w[4:0]);
        end
        else if (w <= 7'd48)
        begin
            t.neg = 1'b0;
            t.mag = sin_mag(5'(7'd48 - w));
        end
        else if (w <= 7'd72)
        begin
            t.neg = 1'b1;
            t.mag = sin_mag(5'(w - 7'd48));
        end
        else
        begin
            t.neg = 1'b1;
            t.mag = sin_mag(5'(7'd96 - w));
        end
        return t;
    endfunction

    // gray to binary, prefix xor from the top
    function automatic logic [5:0] gray_dec6(input logic [5:0] g);
        logic [5:0] b;
        b[5] = g[5];
        for (int i = 4; i >= 0; i--)
        begin
            b[i] = b[i+1] ^ g[i];
        end
        return b;
    endfunction

    // bits per symbol for a mode, zero for unused codes
    function automatic logic [3:0] sym_len(input logic [MODE_W-1:0] m);
        logic [3:0] k;
        if (m <= MODE_PSK16)
            k = 4'(m + 5'd1);
        else if (m <= MODE_QAM4096)
            k = m[3:0];
        else if (m == MODE_APSK16 || m == MODE_STAR16)
            k = 4'd4;
        else if (m == MODE_APSK32 || m == MODE_STAR32)
            k = 4'd5;
        else
            k = 4'd0;
        return k;
    endfunction

    // cross qam region offsets
    function automatic logic [1:0] cross_bx(input logic [2:0] r);
        logic [1:0] b;
        case (r)
            3'd0:    b = 2'd0;
            3'd1:    b = 2'd1;
            3'd2:    b = 2'd1;
            3'd3:    b = 2'd2;
            3'd4:    b = 2'd0;
            3'd5:    b = 2'd1;
            3'd6:    b = 2'd0;
            3'd7:    b = 2'd2;
            default: b = 2'd0;
        endcase
        return b;
    endfunction

    function automatic logic [1:0] cross_by(input logic [2:0] r);
        logic [1:0] b;
        case (r)
            3'd0:    b = 2'd0;
            3'd1:    b = 2'd0;
            3'd2:    b = 2'd2;
            3'd3:    b = 2'd0;
            3'd4:    b = 2'd1;
            3'd5:    b = 2'd1;
            3'd6:    b = 2'd2;
            3'd7:    b = 2'd1;
            default: b = 2'd0;
        endcase
        return b;
    endfunction

    // apsk16 angle in pi/48 steps
    function automatic logic [ANG_W-1:0] apsk16_ang(input logic [3:0] v);
        logic [ANG_W-1:0] a;
        case (v[2:0])
            3'd0:    a = 7'd12;
            3'd1:    a = 7'd84;
            3'd2:    a = 7'd36;
            3'd3:    a = 7'd60;
            3'd4:    a = v[3] ? 7'd12 : 7'd4;
            3'd5:    a = v[3] ? 7'd84 : 7'd92;
            3'd6:    a = v[3] ? 7'd36 : 7'd44;
            3'd7:    a = v[3] ? 7'd60 : 7'd52;
            default: a = 7'd0;
        endcase
        if (v[3] && !v[2])
        begin
            case (v[1:0])
                2'd0:    a = 7'd20;
                2'd1:    a = 7'd76;
                2'd2:    a = 7'd28;
                2'd3:    a = 7'd68;
                default: a = 7'd0;
            endcase
        end
        return a;
    endfunction

    // apsk32 angle in pi/48 steps
    function automatic logic [ANG_W-1:0] apsk32_ang(input logic [4:0] v);
        logic [ANG_W-1:0] a;
        case (v)
            5'd0:    a = 7'd12;
            5'd1:    a = 7'd20;
            5'd2:    a = 7'd84;
            5'd3:    a = 7'd76;
            5'd4:    a = 7'd36;
            5'd5:    a = 7'd28;
            5'd6:    a = 7'd60;
            5'd7:    a = 7'd68;
            5'd8:    a = 7'd6;
            5'd9:    a = 7'd18;
            5'd10:   a = 7'd84;
            5'd11:   a = 7'd72;
            5'd12:   a = 7'd36;
            5'd13:   a = 7'd24;
            5'd14:   a = 7'd54;
            5'd15:   a = 7'd66;
            5'd16:   a = 7'd4;
            5'd17:   a = 7'd12;
            5'd18:   a = 7'd92;
            5'd19:   a = 7'd84;
            5'd20:   a = 7'd44;
            5'd21:   a = 7'd36;
            5'd22:   a = 7'd52;
            5'd23:   a = 7'd60;
            5'd24:   a = 7'd0;
            5'd25:   a = 7'd12;
            5'd26:   a = 7'd90;
            5'd27:   a = 7'd78;
            5'd28:   a = 7'd42;
            5'd29:   a = 7'd30;
            5'd30:   a = 7'd48;
            5'd31:   a = 7'd60;
            default: a = 7'd0;
        endcase
        return a;
    endfunction

    // apsk32 ring: 0 inner, 1 middle, 2 outer
    function automatic logic [1:0] apsk32_ring(input logic [4:0] v);
        logic [1:0] r;
        if (v[3])
            r = 2'd2;
        else if (v[4] && v[0])
            r = 2'd0;
        else
            r = 2'd1;
        return r;
    endfunction

    // star32 phase order
    function automatic logic [2:0] star32_phase(input logic [2:0] v);
        logic [2:0] p;
        case (v)
            3'd0:    p = 3'd0;
            3'd1:    p = 3'd3;
            3'd2:    p = 3'd1;
            3'd3:    p = 3'd2;
            3'd4:    p = 3'd7;
            3'd5:    p = 3'd4;
            3'd6:    p = 3'd6;
            3'd7:    p = 3'd5;
            default: p = 3'd0;
        endcase
        return p;
    endfunction

endpackage

// File: design/constellation_symbol_mapper.sv
// ----------------------------------------------------------------------------
// constellation_symbol_mapper
// Maps one symbol's bits to a scaled, saturated complex point.
// ----------------------------------------------------------------------------
// Takes one symbol per clock and returns one point per symbol, passing it
// through bit ordering, point construction from the mode's rules, the
// radius-times-trig multiply, the normalization-gain multiply, then rounding
// and saturation, each in a register stage of its own. The whole pipeline
// moves together, so a symbol is accepted in every cycle in which the output
// register is empty or being taken. The user must write configuration through
// the write port only while no symbol is in flight; the block does not enforce
// this. It needs no clearing after reset.
module constellation_symbol_mapper #(
    parameter int MAX_SYMBOL_BITS = cmap_pkg::MAX_SYMBOL_BITS,
    parameter int SAMPLE_WIDTH    = cmap_pkg::SAMPLE_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  wr_en,
    input  logic [cmap_pkg::CFG_IDX_W-1:0]        wr_index,
    input  logic [cmap_pkg::CFG_DATA_W-1:0]       wr_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [15:0]                           s_tdata,  // symbol_bits[11:0]
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // i_out, q_out, zero fill to whole bytes
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata,
    output logic                                  m_tuser   // clipped
);

    localparam int OUT_W = ((2*SAMPLE_WIDTH+7)/8)*8;
    localparam int M_W   = 19;
    localparam int P_W   = M_W + cmap_pkg::TRIG_W;
    localparam int G_W   = P_W + cmap_pkg::GAIN_W;
    localparam int SHIFT = 45 - SAMPLE_WIDTH;
    localparam int R_W   = G_W - SHIFT;
    localparam logic [R_W-1:0] LIM  = R_W'(1) << (SAMPLE_WIDTH - 1);
    localparam logic [G_W-1:0] HALF = G_W'(1) << (SHIFT - 1);
    localparam logic [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    // configuration registers
    logic [cmap_pkg::MODE_W-1:0]  mode_reg;
    logic                         bit_order_reg;
    logic [cmap_pkg::RATIO_W-1:0] ratio_two_reg;
    logic [cmap_pkg::RATIO_W-1:0] ratio_three_reg;
    logic [cmap_pkg::RATIO_W-1:0] ratio_four_reg;
    logic [cmap_pkg::GAIN_W-1:0]  norm_gain_reg;

    // pipeline valid bits
    logic v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic adv;

    // stage 1
    logic [3:0]                 k;
    logic                       ok;
    logic [3:0]                 src;
    logic [MAX_SYMBOL_BITS-1:0] idx_next, idx_reg;
    logic                       ok_reg;

    // stage 2
    logic [11:0]                 v12;
    logic [5:0]                  g;
    logic [cmap_pkg::ANG_W-1:0]  ang;
    logic [cmap_pkg::RATIO_W-1:0] rad;
    logic                        is_qam;
    logic [1:0]                  ring;
    logic [2:0]                  ph;
    cmap_pkg::trig_t             t_cos, t_sin;
    int                          kk, ins, axis, loc;
    logic [1:0]                  q2;
    logic [11:0]                 r;
    logic [5:0]                  ig, qg, ir, qr, mask6;
    logic [2:0]                  region;
    logic [11:0]                 rem;
    logic [1:0]                  bx, by;
    logic [6:0]                  la, lb, li, lq;
    logic                        li_neg, lq_neg;
    logic [M_W-1:0]              mi_next, mq_next, mi_reg, mq_reg;
    logic [cmap_pkg::TRIG_W-1:0] ti_next, tq_next, ti_reg, tq_reg;
    logic                        ni_next, nq_next, ni_reg, nq_reg;

    // stage 3 and 4
    logic [P_W-1:0] pi_reg, pq_reg;
    logic           n3i_reg, n3q_reg;
    logic [G_W-1:0] gi_reg, gq_reg;
    logic           n4i_reg, n4q_reg;

    // output stage
    logic [SAMPLE_WIDTH:0]   sat_i, sat_q;
    logic [SAMPLE_WIDTH-1:0] i_reg, q_reg;
    logic                    clip_reg;

    // register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= cmap_pkg::MODE_RST;
            bit_order_reg   <= 1'b0;
            ratio_two_reg   <= cmap_pkg::RATIO_TWO_RST;
            ratio_three_reg <= cmap_pkg::RATIO_THREE_RST;
            ratio_four_reg  <= cmap_pkg::RATIO_FOUR_RST;
            norm_gain_reg   <= cmap_pkg::NORM_GAIN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                cmap_pkg::REG_MODE:        mode_reg        <= wr_data[cmap_pkg::MODE_W-1:0];
                cmap_pkg::REG_BIT_ORDER:   bit_order_reg   <= wr_data[0];
                cmap_pkg::REG_RATIO_TWO:   ratio_two_reg   <= wr_data[cmap_pkg::RATIO_W-1:0];
                cmap_pkg::REG_RATIO_THREE: ratio_three_reg <= wr_data[cmap_pkg::RATIO_W-1:0];
                cmap_pkg::REG_RATIO_FOUR:  ratio_four_reg  <= wr_data[cmap_pkg::RATIO_W-1:0];
                cmap_pkg::REG_NORM_GAIN:   norm_gain_reg   <= wr_data[cmap_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline advance: all stages move when the output can take a request
    assign adv      = !vo_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            vo_reg <= v4_reg;
        end
    end

    // stage 1: symbol length and bit order
    always_comb
    begin
        k   = cmap_pkg::sym_len(mode_reg);
        ok  = (k != 4'd0) && (int'(k) <= MAX_SYMBOL_BITS);
        src = '0;
        for (int j = 0; j < MAX_SYMBOL_BITS; j++)
        begin
            src = 4'(int'(k) - 1 - j);
            if (ok && (j < int'(k)))
                idx_next[j] = bit_order_reg ? s_tdata[src] : s_tdata[j];
            else
                idx_next[j] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            idx_reg <= idx_next;
            ok_reg  <= ok;
        end
    end

    // stage 2: qam levels or polar radius and angle
    always_comb
    begin
        v12    = 12'(idx_reg);
        g      = cmap_pkg::gray_dec6(v12[5:0]);
        ang    = '0;
        rad    = '0;
        is_qam = 1'b0;
        ring   = cmap_pkg::apsk32_ring(v12[4:0]);
        ph     = {v12[3], v12[1] ^ v12[3], v12[1] ^ v12[2] ^ v12[3]};
        kk     = int'(mode_reg[3:0]);
        ins    = kk - 2;
        axis   = kk / 2 - 1;
        loc    = (kk - 1) / 2 - 2;
        q2     = 2'(v12 >> ins);
        r      = v12 & 12'((1 << ins) - 1);
        ig     = '0;
        qg     = '0;
        for (int b = 0; b < 5; b++)
        begin
            ig[b] = r[2*b];
            qg[b] = r[2*b+1];
        end
        region = 3'(r >> (2 * loc));
        rem    = r & 12'((1 << (2 * loc)) - 1);
        bx     = cmap_pkg::cross_bx(region);
        by     = cmap_pkg::cross_by(region);
        ir     = cmap_pkg::gray_dec6(ig);
        qr     = cmap_pkg::gray_dec6(qg);
        mask6  = 6'((1 << axis) - 1);
        la     = '0;
        lb     = '0;
        li     = '0;
        lq     = '0;
        li_neg = 1'b0;
        lq_neg = 1'b0;

        if (mode_reg inside {[cmap_pkg::MODE_QAM16:cmap_pkg::MODE_QAM4096]})
        begin
            is_qam = 1'b1;
            if (kk[0])
            begin
                // cross: region offset plus gray-decoded local position
                ig = '0;
                qg = '0;
                for (int b = 0; b < 3; b++)
                begin
                    ig[b] = rem[2*b];
                    qg[b] = rem[2*b+1];
                end
                ir = cmap_pkg::gray_dec6(ig);
                qr = cmap_pkg::gray_dec6(qg);
                mask6 = 6'((1 << loc) - 1);
                if (bx[0])
                    ir = ~ir & mask6;
                if (by[0])
                    qr = ~qr & mask6;
                la = 7'(2 * ((int'(bx) << loc) + int'(ir)) + 1);
                lb = 7'(2 * ((int'(by) << loc) + int'(qr)) + 1);
            end
            else if (kk >= 10)
            begin
                la = 7'(2 * int'(~ir & mask6) + 1);
                lb = 7'(2 * int'(~qr & mask6) + 1);
            end
            else
            begin
                la = 7'(2 * int'(ir) + 1);
                lb = 7'(2 * int'(qr) + 1);
            end

            // quadrant placement, sign flips only for the large squares
            if (!kk[0] && kk >= 10)
            begin
                li = la; lq = lb; li_neg = q2[0]; lq_neg = q2[1];
            end
            else
            begin
                case (q2)
                    2'd1:    begin li = lb; lq = la; li_neg = 1'b0; lq_neg = 1'b1; end
                    2'd2:    begin li = lb; lq = la; li_neg = 1'b1; lq_neg = 1'b0; end
                    2'd3:    begin li = la; lq = lb; li_neg = 1'b1; lq_neg = 1'b1; end
                    default: begin li = la; lq = lb; li_neg = 1'b0; lq_neg = 1'b0; end
                endcase
            end
        end
        else
        begin
            case (mode_reg)
                cmap_pkg::MODE_BPSK:
                begin
                    rad = cmap_pkg::RADIUS_ONE;
                    ang = v12[0] ? 7'd48 : 7'd0;
                end
                cmap_pkg::MODE_QPSK:
                begin
                    rad = cmap_pkg::RADIUS_ONE;
                    ang = 7'(12 + 24 * int'(g[1:0]));
                end
                cmap_pkg::MODE_PSK8:
                begin
                    rad = cmap_pkg::RADIUS_ONE;
                    ang = 7'(6 + 12 * int'(g[2:0]));
                end
                cmap_pkg::MODE_PSK16:
                begin
                    rad = cmap_pkg::RADIUS_ONE;
                    ang = 7'(3 + 6 * int'(g[3:0]));
                end
                cmap_pkg::MODE_APSK16:
                begin
                    rad = (v12 < 12'd12) ? ratio_two_reg : cmap_pkg::RADIUS_ONE;
                    ang = cmap_pkg::apsk16_ang(v12[3:0]);
                end
                cmap_pkg::MODE_APSK32:
                begin
                    case (ring)
                        2'd0:    rad = cmap_pkg::RADIUS_ONE;
                        2'd1:    rad = ratio_two_reg;
                        default: rad = ratio_three_reg;
                    endcase
                    ang = cmap_pkg::apsk32_ang(v12[4:0]);
                end
                cmap_pkg::MODE_STAR16:
                begin
                    rad = v12[0] ? ratio_two_reg : cmap_pkg::RADIUS_ONE;
                    ang = 7'(12 * int'(ph));
                end
                cmap_pkg::MODE_STAR32:
                begin
                    case (v12[1:0])
                        2'd0:    rad = cmap_pkg::RADIUS_ONE;
                        2'd1:    rad = ratio_two_reg;
                        2'd2:    rad = ratio_four_reg;
                        default: rad = ratio_three_reg;
                    endcase
                    ang = 7'(12 * int'(cmap_pkg::star32_phase(v12[4:2])));
                end
                default:
                begin
                    rad = '0;
                    ang = '0;
                end
            endcase
        end

        t_cos = cmap_pkg::trig_at(7'(ang + 7'd24));
        t_sin = cmap_pkg::trig_at(ang);

        if (!ok_reg)
        begin
            mi_next = '0; mq_next = '0;
            ti_next = '0; tq_next = '0;
            ni_next = 1'b0; nq_next = 1'b0;
        end
        else if (is_qam)
        begin
            mi_next = {li, 12'd0};
            mq_next = {lq, 12'd0};
            ti_next = cmap_pkg::TRIG_ONE;
            tq_next = cmap_pkg::TRIG_ONE;
            ni_next = li_neg;
            nq_next = lq_neg;
        end
        else
        begin
            mi_next = M_W'(rad);
            mq_next = M_W'(rad);
            ti_next = t_cos.mag;
            tq_next = t_sin.mag;
            ni_next = t_cos.neg;
            nq_next = t_sin.neg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mi_reg <= mi_next;
            mq_reg <= mq_next;
            ti_reg <= ti_next;
            tq_reg <= tq_next;
            ni_reg <= ni_next;
            nq_reg <= nq_next;
        end
    end

    // stage 3: radius times trig magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pi_reg  <= P_W'(mi_reg) * P_W'(ti_reg);
            pq_reg  <= P_W'(mq_reg) * P_W'(tq_reg);
            n3i_reg <= ni_reg;
            n3q_reg <= nq_reg;
        end
    end

    // stage 4: normalization gain
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gi_reg  <= G_W'(pi_reg) * G_W'(norm_gain_reg);
            gq_reg  <= G_W'(pq_reg) * G_W'(norm_gain_reg);
            n4i_reg <= n3i_reg;
            n4q_reg <= n3q_reg;
        end
    end

    // round half up on the magnitude, restore sign, saturate
    function automatic logic [SAMPLE_WIDTH:0] round_sat(input logic [G_W-1:0] gm,
                                                        input logic neg);
        logic [R_W-1:0]          rr;
        logic                    c;
        logic [SAMPLE_WIDTH-1:0] val;
        rr = R_W'((gm + HALF) >> SHIFT);
        c  = 1'b0;
        if (neg)
        begin
            if (rr > LIM)
            begin
                c   = 1'b1;
                val = S_MIN;
            end
            else
                val = SAMPLE_WIDTH'(-rr);
        end
        else
        begin
            if (rr > LIM - R_W'(1))
            begin
                c   = 1'b1;
                val = S_MAX;
            end
            else
                val = SAMPLE_WIDTH'(rr);
        end
        return {c, val};
    endfunction

    assign sat_i = round_sat(gi_reg, n4i_reg);
    assign sat_q = round_sat(gq_reg, n4q_reg);

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_reg    <= sat_i[SAMPLE_WIDTH-1:0];
            q_reg    <= sat_q[SAMPLE_WIDTH-1:0];
            clip_reg <= sat_i[SAMPLE_WIDTH] | sat_q[SAMPLE_WIDTH];
        end
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = OUT_W'({q_reg, i_reg});
    assign m_tuser  = clip_reg;

`ifndef ASSERT_OFF
    // a clipped point has a component at a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (i_reg == S_MAX || i_reg == S_MIN ||
                                   q_reg == S_MAX || q_reg == S_MIN))
        else $error("clipped flag without saturated component");

    // a request in the last stage reaches the output when the pipe moves
    a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && adv) |=> m_tvalid)
        else $error("request lost between gain stage and output");
`endif

endmodule

// File: sim/mapper_checker.sv
// ----------------------------------------------------------------------------
// mapper_checker
// Watches the symbol and point streams of the constellation symbol mapper,
// predicts each point from its own copy of the registers and compares.
// ----------------------------------------------------------------------------
module mapper_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [cmap_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [cmap_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // symbol_bits[11:0]
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [31:0]                       m_tdata,  // i_out, q_out
    input  logic                              m_tuser,  // clipped
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] i_pt;
        logic [15:0] q_pt;
        logic        clip;
    } point_t;

    typedef struct {
        longint re;
        longint im;
    } raw_pt_t;

    localparam int SINE_Q [25] = '{0, 1072, 2139, 3196, 4240, 5266, 6270, 7246, 8192,
        9102, 9974, 10803, 11585, 12318, 12998, 13623, 14189, 14694, 15137, 15515,
        15826, 16069, 16244, 16349, 16384};
    localparam int CR_BX [8] = '{0, 1, 1, 2, 0, 1, 0, 2};
    localparam int CR_BY [8] = '{0, 0, 2, 0, 1, 1, 2, 1};
    localparam int A16_ANG [16] = '{12, 84, 36, 60, 4, 92, 44, 52, 20, 76, 28, 68,
        12, 84, 36, 60};
    localparam int A32_ANG [32] = '{12, 20, 84, 76, 36, 28, 60, 68, 6, 18, 84, 72,
        36, 24, 54, 66, 4, 12, 92, 84, 44, 36, 52, 60, 0, 12, 90, 78, 42, 30, 48, 60};
    localparam int A32_RING [32] = '{1, 1, 1, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 2, 2, 2,
        1, 0, 1, 0, 1, 0, 1, 0, 2, 2, 2, 2, 2, 2, 2, 2};
    localparam int S32_PH [8] = '{0, 3, 1, 2, 7, 4, 6, 5};

    logic [cmap_pkg::MODE_W-1:0]  cur_mode;
    logic                         rev_order;
    logic [cmap_pkg::RATIO_W-1:0] ring2, ring3, ring4;
    logic [cmap_pkg::GAIN_W-1:0]  gain;
    point_t                       points_due [$];

    function automatic longint sine_of(int a);
        a = a % 96;
        if (a <= 24) return SINE_Q[a];
        if (a <= 48) return SINE_Q[48 - a];
        if (a <= 72) return -SINE_Q[a - 48];
        return -SINE_Q[96 - a];
    endfunction

    function automatic raw_pt_t on_ring(longint rad, int a);
        raw_pt_t p;
        p.re = rad * sine_of(a + 24);
        p.im = rad * sine_of(a);
        return p;
    endfunction

    function automatic int ungray(int g);
        int b;
        b = 0;
        while (g != 0)
        begin
            b ^= g;
            g >>= 1;
        end
        return b;
    endfunction

    function automatic raw_pt_t quad_rot(int q2, longint a, longint b);
        raw_pt_t p;
        case (q2 & 3)
            1:       begin p.re = b;  p.im = -a; end
            2:       begin p.re = -b; p.im = a;  end
            3:       begin p.re = -a; p.im = -b; end
            default: begin p.re = a;  p.im = b;  end
        endcase
        p.re = p.re <<< 26;
        p.im = p.im <<< 26;
        return p;
    endfunction

    // square and cross qam, level units before scaling
    function automatic raw_pt_t qam_point(int k, int v);
        int ins, q2, r, ax, ig, qg, n, loc, c, rb, reg3, rem, x, y, bx, by;
        longint li, lq;
        raw_pt_t p;
        ins = k - 2;
        q2 = (v >> ins) & 3;
        r = v & ((1 << ins) - 1);
        ig = 0;
        qg = 0;
        if ((k & 1) == 0)
        begin
            ax = k / 2 - 1;
            for (int b = 0; b < ax; b++)
            begin
                ig |= ((r >> (2 * b)) & 1) << b;
                qg |= ((r >> (2 * b + 1)) & 1) << b;
            end
            ig = ungray(ig);
            qg = ungray(qg);
            if (k == 10 || k == 12)
            begin
                li = 2 * (((1 << ax) - 1) - ig) + 1;
                lq = 2 * (((1 << ax) - 1) - qg) + 1;
                if (q2 & 1) li = -li;
                if (q2 & 2) lq = -lq;
                p.re = li <<< 26;
                p.im = lq <<< 26;
                return p;
            end
            return quad_rot(q2, 2 * ig + 1, 2 * qg + 1);
        end
        n = (k - 1) / 2;
        loc = n - 2;
        c = 1 << loc;
        rb = 2 * loc;
        reg3 = (r >> rb) & 7;
        rem = r & ((1 << rb) - 1);
        for (int b = 0; b < loc; b++)
        begin
            ig |= ((rem >> (2 * b)) & 1) << b;
            qg |= ((rem >> (2 * b + 1)) & 1) << b;
        end
        x = ungray(ig);
        y = ungray(qg);
        bx = CR_BX[reg3];
        by = CR_BY[reg3];
        if ((bx & 1) && c > 1) x = c - 1 - x;
        if ((by & 1) && c > 1) y = c - 1 - y;
        return quad_rot(q2, 2 * (bx * c + x) + 1, 2 * (by * c + y) + 1);
    endfunction

    // gain, round half up on magnitude, saturate
    function automatic logic [15:0] scale_sat(longint raw, ref logic clip);
        longint unsigned mag, r;
        mag = (raw < 0) ? longint'(-raw) : longint'(raw);
        r = (mag * gain + (64'd1 << 28)) >> 29;
        if (raw < 0)
        begin
            if (r > 32768)
            begin
                r = 32768;
                clip = 1'b1;
            end
            return 16'(-r);
        end
        if (r > 32767)
        begin
            r = 32767;
            clip = 1'b1;
        end
        return 16'(r);
    endfunction

    function automatic point_t map_symbol(logic [11:0] bits);
        int k, v, m, ph, sel;
        longint rad;
        raw_pt_t p;
        point_t res;
        logic clip;
        m = int'(cur_mode);
        k = (m <= int'(cmap_pkg::MODE_PSK16)) ? m + 1 :
            (m <= int'(cmap_pkg::MODE_QAM4096)) ? m :
            (m == int'(cmap_pkg::MODE_APSK16) || m == int'(cmap_pkg::MODE_STAR16)) ? 4 :
            (m == int'(cmap_pkg::MODE_APSK32) || m == int'(cmap_pkg::MODE_STAR32)) ? 5 : 0;
        p.re = 0;
        p.im = 0;
        v = 0;
        clip = 1'b0;
        if (k != 0)
        begin
            if (!rev_order)
                v = bits & ((1 << k) - 1);
            else
                for (int i = 0; i < k; i++)
                    v = (v << 1) | bits[i];
            if (m == int'(cmap_pkg::MODE_BPSK))
                p = on_ring(4096, 48 * v);
            else if (m <= int'(cmap_pkg::MODE_PSK16))
                p = on_ring(4096, 48 / (1 << k) + (96 / (1 << k)) * ungray(v));
            else if (m <= int'(cmap_pkg::MODE_QAM4096))
                p = qam_point(k, v);
            else if (m == int'(cmap_pkg::MODE_APSK16))
                p = on_ring(v < 12 ? ring2 : 4096, A16_ANG[v]);
            else if (m == int'(cmap_pkg::MODE_APSK32))
            begin
                rad = A32_RING[v] == 0 ? 4096 : A32_RING[v] == 1 ? ring2 : ring3;
                p = on_ring(rad, A32_ANG[v]);
            end
            else if (m == int'(cmap_pkg::MODE_STAR16))
            begin
                ph = (((v >> 1) ^ (v >> 2) ^ (v >> 3)) & 1) |
                     ((((v >> 1) ^ (v >> 3)) & 1) << 1) | (((v >> 3) & 1) << 2);
                p = on_ring((v & 1) ? ring2 : 4096, 12 * ph);
            end
            else
            begin
                sel = v & 3;
                rad = sel == 0 ? 4096 : sel == 1 ? ring2 : sel == 2 ? ring4 : ring3;
                p = on_ring(rad, 12 * S32_PH[(v >> 2) & 7]);
            end
        end
        res.i_pt = scale_sat(p.re, clip);
        res.q_pt = scale_sat(p.im, clip);
        res.clip = clip;
        return res;
    endfunction

    assign pending = points_due.size();

    // register shadow, predict on request, compare on result
    always @(posedge clk or negedge rst_n)
    begin
        point_t want;
        point_t got;
        if (!rst_n)
        begin
            cur_mode  <= cmap_pkg::MODE_RST;
            rev_order <= 1'b0;
            ring2     <= cmap_pkg::RATIO_TWO_RST;
            ring3     <= cmap_pkg::RATIO_THREE_RST;
            ring4     <= cmap_pkg::RATIO_FOUR_RST;
            gain      <= cmap_pkg::NORM_GAIN_RST;
            points_due.delete();
            fail_count <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                points_due.insert(points_due.size(), map_symbol(s_tdata[11:0]));
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[15:0], m_tdata[31:16], m_tuser};
                if (points_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("mismatch: unexpected point %h", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = points_due.pop_front();
                    if (want !== got)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: i exp %h got %h, q exp %h got %h, clip exp %b got %b",
                                     want.i_pt, got.i_pt, want.q_pt, got.q_pt,
                                     want.clip, got.clip);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    cmap_pkg::REG_MODE:        cur_mode  <= wr_data[cmap_pkg::MODE_W-1:0];
                    cmap_pkg::REG_BIT_ORDER:   rev_order <= wr_data[0];
                    cmap_pkg::REG_RATIO_TWO:   ring2     <= wr_data[cmap_pkg::RATIO_W-1:0];
                    cmap_pkg::REG_RATIO_THREE: ring3     <= wr_data[cmap_pkg::RATIO_W-1:0];
                    cmap_pkg::REG_RATIO_FOUR:  ring4     <= wr_data[cmap_pkg::RATIO_W-1:0];
                    cmap_pkg::REG_NORM_GAIN:   gain      <= wr_data[cmap_pkg::GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives symbols and register settings into the constellation symbol mapper
// across all modes, bit orders, ring ratios and gains with random idling.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                            clk;
    logic                            rst_n;
    logic                            wr_en;
    logic [cmap_pkg::CFG_IDX_W-1:0]  wr_index;
    logic [cmap_pkg::CFG_DATA_W-1:0] wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [15:0]                     s_tdata;   // symbol_bits[11:0]
    logic                            m_tvalid;
    logic                            m_tready;
    logic [31:0]                     m_tdata;   // i_out, q_out
    logic                            m_tuser;   // clipped
    int                              fail_count;
    int                              pending;
    int                              send_idle;
    int                              recv_stall;
    int                              hold_off;

    constellation_symbol_mapper i_dut (.*);

    mapper_checker i_chk (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // timeout
    initial
    begin
        #100ms;
        $display("FAIL constellation_symbol_mapper");
        $finish;
    end

    // receiver: random stall, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                m_tready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // stop sending, wait for drain, then let the pipeline settle
    task automatic drain;
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic write_reg(input logic [cmap_pkg::CFG_IDX_W-1:0] idx, input int val);
        drain();
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= cmap_pkg::CFG_DATA_W'(val);
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic send_symbol(input logic [11:0] bits);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, bits};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 77; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 77; end
            default: begin send_idle = 24; recv_stall = 24; end
        endcase
    endtask

    initial
    begin
        int m;
        int burst;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, field extremes, unused mode, zero ratio
        send_symbol(12'h000);
        send_symbol(12'hFFF);
        send_symbol(12'h002);
        send_symbol(12'h003);
        drain();
        write_reg(cmap_pkg::REG_MODE, 17);
        send_symbol(12'hFFF);
        write_reg(cmap_pkg::REG_MODE, 31);
        send_symbol(12'h5A5);
        write_reg(cmap_pkg::REG_RATIO_TWO, 0);
        write_reg(cmap_pkg::REG_MODE, cmap_pkg::MODE_STAR16);
        send_symbol(12'h001);
        send_symbol(12'hFF0);
        write_reg(cmap_pkg::REG_NORM_GAIN, 262143);
        write_reg(cmap_pkg::REG_MODE, cmap_pkg::MODE_QAM4096);
        send_symbol(12'h000);
        send_symbol(12'hFFF);
        write_reg(cmap_pkg::REG_BIT_ORDER, 1);
        send_symbol(12'hAAA);
        write_reg(cmap_pkg::REG_NORM_GAIN, 0);
        send_symbol(12'h555);
        drain();

        // random phases through every mode and register setting
        for (int ph = 0; ph < 40; ph++)
        begin
            set_idling(ph);
            m = (ph < 17) ? ph : $urandom_range(18);
            if (ph % 9 == 8) m = $urandom_range(31);
            write_reg(cmap_pkg::REG_MODE, m);
            write_reg(cmap_pkg::REG_BIT_ORDER, $urandom_range(1));
            write_reg(cmap_pkg::REG_RATIO_TWO, (ph % 5 == 0) ? 65535 : (ph % 7 == 0) ? 0
                      : $urandom_range(65535));
            write_reg(cmap_pkg::REG_RATIO_THREE, (ph % 6 == 1) ? 65535
                      : $urandom_range(65535));
            write_reg(cmap_pkg::REG_RATIO_FOUR, (ph % 6 == 2) ? 1 : $urandom_range(65535));
            write_reg(cmap_pkg::REG_NORM_GAIN, (ph % 8 == 3) ? 262143 : (ph % 8 == 5)
                      ? 46341 : $urandom_range(262143));
            burst = 30;
            if (ph == 10)
                hold_off = 300;
            for (int n = 0; n < burst; n++)
            begin
                send_symbol(12'($urandom));
                if (ph == 20 && n == 15)
                begin
                    s_tvalid <= 1'b0;
                    while (pending != 0)
                        @(negedge clk);
                end
            end
            drain();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("PASS constellation_symbol_mapper");
        else
            $display("FAIL constellation_symbol_mapper");
        $finish;
    end

endmodule

// File: constellation_symbol_mapper.f
design/cmap_pkg.sv
design/constellation_symbol_mapper.sv
sim/mapper_checker.sv
sim/tb.sv
